@@ rtl/skvt_pkg.sv @@
// Shared types and constants for the small key/value table.
package skvt_pkg;

  localparam int unsigned CAPACITY = 10;
  localparam int unsigned KEY_W    = 32;
  localparam int unsigned VAL_W    = 32;
  localparam int unsigned TOL_W    = 16;
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned ADDR_W   = 3;
  localparam int unsigned DATA_W   = 32;

  // Register index of match_tolerance, taken from paddr[2].
  localparam logic REG_TOLERANCE = 1'b0;

  typedef enum logic [0:0] {
    CMD_SET    = 1'b0,
    CMD_LOOKUP = 1'b1
  } cmd_e;

  typedef enum logic [2:0] {
    ST_UPDATED   = 3'd0,
    ST_INSERTED  = 3'd1,
    ST_FULL      = 3'd2,
    ST_FOUND     = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_e;

  // Transaction token that walks down the row of cells.
  typedef struct packed {
    logic             valid;
    cmd_e             cmd;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
    logic             done;
    status_e          status;
    logic [VAL_W-1:0] fval;
    logic             inc;
  } tok_t;

endpackage

@@ rtl/small_key_value_table.sv @@
// Small key/value table: a row of entry cells served by a travelling transaction token.
//
// Usage: an input transaction carries command_i (set or look up), key_i and value_i on a
// valid/ready channel. Each accepted transaction yields exactly one result transaction
// with status_o, found_value_o and entries_used_o on a valid/ready output channel.
// The token visits one cell per cycle; its result passes the finishing stage and then
// the output register before it is valid. Only one item is in the row at a time, so
// the block takes no new item until the last result has moved on from the finishing
// stage into the output register.
// A finished result waits in the output register while the next item is accepted and
// processed; should the receiver still be stalling when that second item completes,
// it is held in a finishing stage and input ready stays low until it can move on.
// The APB port holds match_tolerance at address 0; the user must write it only while
// idle; the block does not enforce this. Reset zeroes the fill count and the tolerance
// but not key/value storage, as entries at or above the fill count are never read.
module small_key_value_table (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          command_i,
  input  logic signed [skvt_pkg::KEY_W-1:0] key_i,
  input  logic signed [skvt_pkg::VAL_W-1:0] value_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [2:0]                    status_o,
  output logic signed [skvt_pkg::VAL_W-1:0] found_value_o,
  output logic [skvt_pkg::CNT_W-1:0]    entries_used_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [skvt_pkg::ADDR_W-1:0]   paddr,
  input  logic [skvt_pkg::DATA_W-1:0]   pwdata,
  output logic [skvt_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);
  import skvt_pkg::*;

  tok_t              chain [CAPACITY+1];
  tok_t              head_tok;
  tok_t              last_tok;
  logic [TOL_W-1:0]  tol_q;
  logic [CNT_W-1:0]  count_q;
  logic              busy_q;
  logic              in_acc;
  logic              fin_valid_q;
  status_e           fin_status_q;
  logic [VAL_W-1:0]  fin_fval_q;
  logic [CNT_W-1:0]  fin_cnt_q;
  logic              out_valid_q;
  status_e           status_q;
  logic [VAL_W-1:0]  found_value_q;
  logic [CNT_W-1:0]  entries_used_q;
  logic              move_out;
  status_e           last_status;
  logic [VAL_W-1:0]  last_fval;
  logic [CNT_W-1:0]  last_cnt;

  assign in_ready_o = !busy_q;
  assign in_acc     = in_valid_i && !busy_q;

  always_comb begin
    head_tok        = '0;
    head_tok.valid  = in_acc;
    head_tok.cmd    = cmd_e'(command_i);
    head_tok.key    = key_i;
    head_tok.value  = value_i;
    head_tok.status = ST_NOT_FOUND;
  end

  assign chain[0] = head_tok;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    skvt_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .tok_i   (chain[g]),
      .idx_i   (CNT_W'(g)),
      .count_i (count_q),
      .tol_i   (tol_q),
      .tok_o   (chain[g+1])
    );
  end

  assign last_tok = chain[CAPACITY];

  // A token that left the row unresolved found no match and no free slot.
  always_comb begin
    if (last_tok.done) begin
      last_status = last_tok.status;
      last_fval   = last_tok.fval;
    end else begin
      last_status = (last_tok.cmd == CMD_SET) ? ST_FULL : ST_NOT_FOUND;
      last_fval   = '0;
    end
    last_cnt = count_q + CNT_W'(last_tok.inc);
  end

  assign move_out = fin_valid_q && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      count_q     <= '0;
      fin_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        busy_q <= 1'b1;
      end else if (move_out) begin
        busy_q <= 1'b0;
      end
      if (last_tok.valid) begin
        count_q     <= last_cnt;
        fin_valid_q <= 1'b1;
      end else if (move_out) begin
        fin_valid_q <= 1'b0;
      end
      if (move_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (last_tok.valid) begin
      fin_status_q <= last_status;
      fin_fval_q   <= last_fval;
      fin_cnt_q    <= last_cnt;
    end
    if (move_out) begin
      status_q       <= fin_status_q;
      found_value_q  <= fin_fval_q;
      entries_used_q <= fin_cnt_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign found_value_o  = found_value_q;
  assign entries_used_o = entries_used_q;

  // Configuration port.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= '0;
    end else if (psel && penable && pwrite && (paddr[2] == REG_TOLERANCE)) begin
      tol_q <= pwdata[TOL_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_TOLERANCE) ? {{(DATA_W - TOL_W){1'b0}}, tol_q} : '0;
  assign pready = 1'b1;

endmodule

@@ rtl/skvt_cell.sv @@
// One table entry: holds a key and value and serves the token passing through.
module skvt_cell (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  skvt_pkg::tok_t          tok_i,
  input  logic [skvt_pkg::CNT_W-1:0] idx_i,
  input  logic [skvt_pkg::CNT_W-1:0] count_i,
  input  logic [skvt_pkg::TOL_W-1:0] tol_i,
  output skvt_pkg::tok_t          tok_o
);
  import skvt_pkg::*;

  logic [KEY_W-1:0] key_q;
  logic [VAL_W-1:0] val_q;
  tok_t             tok_d, tok_q;
  logic             occ;
  logic             hit;
  logic             wr_key;
  logic             wr_val;
  logic [KEY_W:0]   diff;
  logic [KEY_W:0]   mag;

  // Entries below the fill count are occupied; the first free slot is at the count.
  assign occ  = (idx_i < count_i);
  assign diff = {tok_i.key[KEY_W-1], tok_i.key} - {key_q[KEY_W-1], key_q};
  assign mag  = diff[KEY_W] ? (~diff + 1'b1) : diff;
  assign hit  = (mag <= {{(KEY_W + 1 - TOL_W){1'b0}}, tol_i});

  always_comb begin
    tok_d  = tok_i;
    wr_key = 1'b0;
    wr_val = 1'b0;
    if (tok_i.valid && !tok_i.done) begin
      if (occ && hit) begin
        tok_d.done = 1'b1;
        if (tok_i.cmd == CMD_SET) begin
          wr_val       = 1'b1;
          tok_d.status = ST_UPDATED;
        end else begin
          tok_d.status = ST_FOUND;
          tok_d.fval   = val_q;
        end
      end else if (!occ) begin
        // Every occupied entry has already been passed without a match.
        tok_d.done = 1'b1;
        if (tok_i.cmd == CMD_SET) begin
          wr_key       = 1'b1;
          wr_val       = 1'b1;
          tok_d.inc    = 1'b1;
          tok_d.status = ST_INSERTED;
        end else begin
          tok_d.status = ST_NOT_FOUND;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_key) begin
      key_q <= tok_i.key;
    end
    if (wr_val) begin
      val_q <= tok_i.value;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule

@@ rtl/skvt_checker.sv @@
// Port-level checks for the small key/value table, bound to the top level.
module skvt_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic [2:0]                    status_o,
  input logic [skvt_pkg::VAL_W-1:0]    found_value_o,
  input logic [skvt_pkg::CNT_W-1:0]    entries_used_o
);
  import skvt_pkg::*;

  // One item at a time: acceptance drops ready on the following cycle.
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input accepted while an item was in flight");

  a_status_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o <= 3'(ST_NOT_FOUND)))
    else $error("result carries an undefined status");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (entries_used_o <= CNT_W'(CAPACITY)))
    else $error("fill count exceeds capacity");

  a_value_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o != 3'(ST_FOUND))) |-> (found_value_o == '0))
    else $error("value reported on a result that is not a hit");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(status_o) && $stable(found_value_o)))
    else $error("stalled result changed");

endmodule

bind small_key_value_table skvt_checker u_skvt_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .status_o       (status_o),
  .found_value_o  (found_value_o),
  .entries_used_o (entries_used_o)
);
